[design/cch_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cch_pkg;

	localparam int SLOTS_DEF = 150;
	localparam logic [7:0] TOL_RESET = 8'd50;
	localparam logic [7:0] CH_WHITE = 8'hFF;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_CLASSIFY = 2'd1,
		CMD_READ     = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] entry_index;
	} item_t;

	typedef struct packed {
		logic        matched;
		logic        inserted;
		logic        table_full;
		logic [7:0]  slot_index;
		logic [31:0] slot_count;
		logic [7:0]  slot_red;
		logic [7:0]  slot_green;
		logic [7:0]  slot_blue;
	} result_t;

	// one item travelling along the row of slot cells
	typedef struct packed {
		logic        valid;
		logic [1:0]  cmd;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  entry_index;
		logic        hit;
		logic        matched;
		logic [7:0]  slot_index;
		logic [31:0] slot_count;
		logic [7:0]  slot_red;
		logic [7:0]  slot_green;
		logic [7:0]  slot_blue;
	} beat_t;

	// strict window: ref - tol < px < ref + tol
	function automatic logic near_ch(input logic [7:0] px, input logic [7:0] ref_ch,
			input logic [7:0] tol);
		logic [8:0] lo_sum;
		logic [8:0] hi_sum;
		lo_sum = {1'b0, px} + {1'b0, tol};
		hi_sum = {1'b0, ref_ch} + {1'b0, tol};
		return (lo_sum > {1'b0, ref_ch}) && ({1'b0, px} < hi_sum);
	endfunction

endpackage
`default_nettype wire

[design/cch_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cch_cell #(
	parameter int IDX = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     tol,
	input  wire cch_pkg::beat_t beat_in,
	output cch_pkg::beat_t      beat_out
);
	import cch_pkg::*;

	localparam logic [7:0] IDX8 = 8'(IDX);
	localparam bit READABLE = (IDX < 256);

	logic [7:0]  red_q, green_q, blue_q;
	logic [31:0] count_q;
	logic [7:0]  red_d, green_d, blue_d;
	logic [31:0] count_d;
	logic [31:0] count_inc;
	logic        near;
	logic        empty;
	beat_t       beat_d;
	beat_t       beat_q;

	assign near = near_ch(beat_in.red, red_q, tol) && near_ch(beat_in.green, green_q, tol)
		&& near_ch(beat_in.blue, blue_q, tol);
	assign empty = (red_q == CH_WHITE) && (green_q == CH_WHITE) && (blue_q == CH_WHITE);
	assign count_inc = (count_q == '1) ? count_q : count_q + 32'd1;

	always_comb begin
		beat_d  = beat_in;
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		count_d = count_q;
		if (beat_in.valid) begin
			case (beat_in.cmd)
				CMD_CLEAR: begin
					red_d   = CH_WHITE;
					green_d = CH_WHITE;
					blue_d  = CH_WHITE;
					count_d = '0;
				end
				CMD_CLASSIFY: begin
					if (!beat_in.hit && (near || empty)) begin
						if (!near) begin
							red_d   = beat_in.red;
							green_d = beat_in.green;
							blue_d  = beat_in.blue;
						end
						count_d           = count_inc;
						beat_d.hit        = 1'b1;
						beat_d.matched    = near;
						beat_d.slot_index = IDX8;
						beat_d.slot_count = count_inc;
						beat_d.slot_red   = red_d;
						beat_d.slot_green = green_d;
						beat_d.slot_blue  = blue_d;
					end
				end
				CMD_READ: begin
					if (READABLE && beat_in.entry_index == IDX8) begin
						beat_d.slot_count = count_q;
						beat_d.slot_red   = red_q;
						beat_d.slot_green = green_q;
						beat_d.slot_blue  = blue_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= CH_WHITE;
			green_q <= CH_WHITE;
			blue_q  <= CH_WHITE;
			count_q <= '0;
			beat_q  <= '0;
		end else begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			count_q <= count_d;
			beat_q  <= beat_d;
		end
	end

	assign beat_out = beat_q;

endmodule
`default_nettype wire

[design/colour_cluster_histogram_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// colour histogram over a pixel stream, one slot cell per table entry
//
// item channel: drive item with start high; the beat is taken at a clock
// edge where busy is low. busy is high only while a tolerance write waits.
// result channel: each item gives one result on result, with done high for
// exactly one cycle; the receiver cannot stall it.
// tolerance channel: cfg_valid/cfg_ready/cfg_data; cfg_ready is high only
// when no item is in the row of cells.
// path: an accepted item walks the row of SLOTS cells, each registering
// it, before its done cycle; one item per cycle while busy is low, and
// each cell works on a different item.
// reset: all slots white with zero counts, tolerance 50, no item in flight.
// a clear item whitens each slot as it passes that slot's cell.
module colour_cluster_histogram_unit #(
	parameter int SLOTS = cch_pkg::SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cch_pkg::item_t   item,
	output logic                  done,
	output cch_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [7:0]       cfg_data
);
	import cch_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1) + 1;

	logic [7:0]       tol_q;
	logic [CNT_W-1:0] inflight_q;
	logic             accept;
	beat_t            head;
	beat_t            last;
	beat_t            chain [SLOTS+1];

	assign busy      = cfg_valid;
	assign cfg_ready = (inflight_q == '0);
	assign accept    = start && !busy;

	always_comb begin
		head             = '0;
		head.valid       = accept;
		head.cmd         = item.cmd;
		head.red         = item.red;
		head.green       = item.green;
		head.blue        = item.blue;
		head.entry_index = item.entry_index;
		if (item.cmd == CMD_READ) begin
			head.slot_index = item.entry_index;
		end
	end

	assign chain[0] = head;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cch_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tol     (tol_q),
			.beat_in (chain[i]),
			.beat_out(chain[i+1])
		);
	end

	assign last = chain[SLOTS];
	assign done = last.valid;

	always_comb begin
		result.matched    = last.matched;
		result.inserted   = last.hit && !last.matched;
		result.table_full = (last.cmd == CMD_CLASSIFY) && !last.hit;
		result.slot_index = last.slot_index;
		result.slot_count = last.slot_count;
		result.slot_red   = last.slot_red;
		result.slot_green = last.slot_green;
		result.slot_blue  = last.slot_blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			inflight_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			inflight_q <= inflight_q + CNT_W'(accept) - CNT_W'(done);
		end
	end

`ifndef ASSERT_OFF
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> inflight_q != '0)
		else $error("result beat with no item in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({result.matched, result.inserted, result.table_full}))
		else $error("more than one outcome flag set");

	a_accept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !done |=> inflight_q != '0)
		else $error("accepted item not counted in flight");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !done)
		else $error("tolerance written while a result is out");
`endif

endmodule
`default_nettype wire
